/* sv/gnnm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnnm_pkg
// Shared widths, codes and types of the greedy nearest neighbor matcher.
// ----------------------------------------------------------------------------
package gnnm_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int MAX_DIMS   = 8;
	localparam int COORD_W    = 16;
	localparam int IDX_W      = 10;
	localparam int DIM_W      = 3;
	localparam int DIMS_CFG_W = 4;
	localparam int CNT_W      = 11;
	localparam int DIFF_W     = 16;
	localparam int SQ_W       = 32;
	localparam int PAIR_W     = 33;
	localparam int DIST_W     = 35;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic REG_DIMS  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef logic [MAX_DIMS-1:0][COORD_W-1:0] coords_t;

	typedef struct packed {
		logic [DIMS_CFG_W-1:0] dims;
		logic [CNT_W-1:0]      count;
	} cfg_t;

	typedef struct packed {
		logic               coord_en;
		logic               live_en;
		logic [IDX_W-1:0]   addr;
		logic [DIM_W-1:0]   dim;
		logic [COORD_W-1:0] coord;
		logic               live;
	} wr_t;

	typedef struct packed {
		logic              valid;
		logic              live;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] sqd;
	} dres_t;

endpackage

/* sv/gnnm_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnnm_req_if
// Request channel: load or query coordinate beats.
// ----------------------------------------------------------------------------
interface gnnm_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 req_type;
	logic [gnnm_pkg::IDX_W-1:0]           point_index;
	logic [gnnm_pkg::DIM_W-1:0]           dim_index;
	logic signed [gnnm_pkg::COORD_W-1:0]  coord_value;

	modport source (
		output valid, req_type, point_index, dim_index, coord_value,
		input  ready
	);
	modport sink (
		input  valid, req_type, point_index, dim_index, coord_value,
		output ready
	);
endinterface

/* sv/gnnm_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnnm_res_if
// Result channel: one match beat per completed query.
// ----------------------------------------------------------------------------
interface gnnm_res_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [gnnm_pkg::CNT_W-1:0]    match_number;
	logic [gnnm_pkg::DIST_W-1:0]   sq_distance;

	modport source (
		output valid, found, match_number, sq_distance,
		input  ready
	);
	modport sink (
		input  valid, found, match_number, sq_distance,
		output ready
	);
endinterface

/* sv/gnnm_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnnm_cfg
// APB register file: dimension count and point count.
// ----------------------------------------------------------------------------
module gnnm_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gnnm_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [gnnm_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [gnnm_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output gnnm_pkg::cfg_t                      cfg
);

	logic [gnnm_pkg::DIMS_CFG_W-1:0] dims_q;
	logic [gnnm_pkg::CNT_W-1:0]      count_q;
	logic                            wr_en;
	logic                            reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= gnnm_pkg::DIMS_CFG_W'(1);
			count_q <= gnnm_pkg::CNT_W'(1);
		end else if (wr_en) begin
			case (reg_sel)
				gnnm_pkg::REG_DIMS:  dims_q  <= pwdata[gnnm_pkg::DIMS_CFG_W-1:0];
				gnnm_pkg::REG_COUNT: count_q <= pwdata[gnnm_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			gnnm_pkg::REG_DIMS:  prdata = gnnm_pkg::APB_DATA_W'(dims_q);
			gnnm_pkg::REG_COUNT: prdata = gnnm_pkg::APB_DATA_W'(count_q);
			default:             prdata = '0;
		endcase
	end

	assign cfg.dims  = dims_q;
	assign cfg.count = count_q;

endmodule

/* sv/gnnm_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnnm_store
// Point memory: one full point per row plus its live flag, lane writes,
// registered row reads.
// ----------------------------------------------------------------------------
module gnnm_store (
	input  logic                        clk,
	input  gnnm_pkg::wr_t               wr,
	input  logic                        rd_en,
	input  logic [gnnm_pkg::IDX_W-1:0]  rd_addr,
	output gnnm_pkg::coords_t           rd_coords,
	output logic                        rd_live
);

	gnnm_pkg::coords_t coord_mem [gnnm_pkg::MAX_POINTS];
	logic              live_mem  [gnnm_pkg::MAX_POINTS];

	gnnm_pkg::coords_t rd_coords_q;
	logic              rd_live_q;

	always_ff @(posedge clk) begin
		if (wr.coord_en) begin
			coord_mem[wr.addr][wr.dim] <= wr.coord;
		end
		if (wr.live_en) begin
			live_mem[wr.addr] <= wr.live;
		end
		if (rd_en) begin
			rd_coords_q <= coord_mem[rd_addr];
			rd_live_q   <= live_mem[rd_addr];
		end
	end

	assign rd_coords = rd_coords_q;
	assign rd_live   = rd_live_q;

endmodule

/* sv/gnnm_dist.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnnm_dist
// Squared distance pipeline: per-lane difference, square, then a two-level
// registered adder tree.
// ----------------------------------------------------------------------------
module gnnm_dist (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_s1,
	input  logic                              live_s1,
	input  logic [gnnm_pkg::IDX_W-1:0]        idx_s1,
	input  gnnm_pkg::coords_t                 row_s1,
	input  gnnm_pkg::coords_t                 query,
	input  logic [gnnm_pkg::DIMS_CFG_W-1:0]   dims_eff,
	output gnnm_pkg::dres_t                   dres,
	output logic                              busy
);

	localparam int PAIRS = gnnm_pkg::MAX_DIMS / 2;

	logic                              v_s2, v_s3, v_s4, v_s5;
	logic                              live_s2, live_s3, live_s4, live_s5;
	logic [gnnm_pkg::IDX_W-1:0]        idx_s2, idx_s3, idx_s4, idx_s5;
	logic [gnnm_pkg::DIFF_W-1:0]       diff_s2 [gnnm_pkg::MAX_DIMS];
	logic [gnnm_pkg::SQ_W-1:0]         sq_s3   [gnnm_pkg::MAX_DIMS];
	logic [gnnm_pkg::PAIR_W-1:0]       pair_s4 [PAIRS];
	logic [gnnm_pkg::DIST_W-1:0]       dist_s5;
	logic [gnnm_pkg::DIFF_W-1:0]       diff_c  [gnnm_pkg::MAX_DIMS];

	always_comb begin
		logic signed [gnnm_pkg::COORD_W:0] delta;
		logic [gnnm_pkg::COORD_W:0]        mag;
		for (int d = 0; d < gnnm_pkg::MAX_DIMS; d++) begin
			delta = {row_s1[d][gnnm_pkg::COORD_W-1], row_s1[d]}
				- {query[d][gnnm_pkg::COORD_W-1], query[d]};
			mag = delta[gnnm_pkg::COORD_W] ? -delta : delta;
			if (gnnm_pkg::DIMS_CFG_W'(d) < dims_eff) begin
				diff_c[d] = mag[gnnm_pkg::DIFF_W-1:0];
			end else begin
				diff_c[d] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= valid_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		live_s2 <= live_s1;
		idx_s2  <= idx_s1;
		live_s3 <= live_s2;
		idx_s3  <= idx_s2;
		live_s4 <= live_s3;
		idx_s4  <= idx_s3;
		live_s5 <= live_s4;
		idx_s5  <= idx_s4;
		for (int d = 0; d < gnnm_pkg::MAX_DIMS; d++) begin
			diff_s2[d] <= diff_c[d];
			sq_s3[d]   <= diff_s2[d] * diff_s2[d];
		end
		for (int k = 0; k < PAIRS; k++) begin
			pair_s4[k] <= gnnm_pkg::PAIR_W'(sq_s3[2*k]) + gnnm_pkg::PAIR_W'(sq_s3[2*k+1]);
		end
		dist_s5 <= gnnm_pkg::DIST_W'(pair_s4[0]) + gnnm_pkg::DIST_W'(pair_s4[1])
			+ gnnm_pkg::DIST_W'(pair_s4[2]) + gnnm_pkg::DIST_W'(pair_s4[3]);
	end

	assign dres.valid = v_s5;
	assign dres.live  = live_s5;
	assign dres.idx   = idx_s5;
	assign dres.sqd   = dist_s5;
	assign busy       = v_s2 || v_s3 || v_s4 || v_s5;

endmodule

/* sv/greedy_nearest_neighbor_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_nearest_neighbor_match
// Nearest live point search with removal of the matched point.
//
// Usage:
//   req carries one coordinate per beat. A load beat (req_type 0) writes one
//   coordinate of a point; the point turns live on its last coordinate. A
//   query beat (req_type 1) stores one query coordinate; the last one starts
//   a scan of rows 0 .. point_count-1, one full point read per cycle from the
//   point memory. res then carries one beat: found, 1-based match_number and
//   sq_distance, and the matched point is removed. Ties go to the lowest index.
//   Load beats and non-final query beats leave req ready for the next beat. A
//   final query beat starts the scan; each row read from the point memory then
//   passes the distance pipeline (difference, square, pair sum, total), and
//   req is held off until the result is registered.
//   After reset a sweep over all 1024 rows clears every live flag; req is held
//   off meanwhile, APB writes are taken as usual.
//   The result waits in an output register while res is stalled; loads and
//   query coordinates are still accepted, and a next query's scan waits only
//   at its end for the output register to free up.
//   APB: dims_in_use at 0x0, point_count at 0x4.
// ----------------------------------------------------------------------------
module greedy_nearest_neighbor_match (
	input  logic                                clk,
	input  logic                                arst_n,
	gnnm_req_if.sink                            req,
	gnnm_res_if.source                          res,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gnnm_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [gnnm_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [gnnm_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	gnnm_pkg::cfg_t                    cfg;
	gnnm_pkg::wr_t                     wr;
	gnnm_pkg::dres_t                   dres;
	gnnm_pkg::coords_t                 rd_coords;
	gnnm_pkg::coords_t                 qc_q;
	logic                              rd_live;
	logic                              dist_busy;

	logic [2:0]                        state_q;
	logic [gnnm_pkg::IDX_W-1:0]        clr_q;
	logic [gnnm_pkg::IDX_W-1:0]        scan_q;
	logic                              v_s1;
	logic [gnnm_pkg::IDX_W-1:0]        idx_s1;
	logic                              any_q;
	logic [gnnm_pkg::IDX_W-1:0]        best_idx_q;
	logic [gnnm_pkg::DIST_W-1:0]       best_dist_q;
	logic                              out_valid_q;
	logic                              out_found_q;
	logic [gnnm_pkg::CNT_W-1:0]        out_match_q;
	logic [gnnm_pkg::DIST_W-1:0]       out_dist_q;

	logic [gnnm_pkg::DIMS_CFG_W-1:0]   dims_eff;
	logic [gnnm_pkg::CNT_W-1:0]        count_eff;
	logic                              accept;
	logic                              dim_ok;
	logic                              is_last;
	logic                              pidx_ok;
	logic                              out_free;
	logic                              best_upd;
	logic                              scan_end;

	gnnm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gnnm_store u_store (
		.clk       (clk),
		.wr        (wr),
		.rd_en     (state_q == ST_SCAN),
		.rd_addr   (scan_q),
		.rd_coords (rd_coords),
		.rd_live   (rd_live)
	);

	gnnm_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (v_s1),
		.live_s1  (rd_live),
		.idx_s1   (idx_s1),
		.row_s1   (rd_coords),
		.query    (qc_q),
		.dims_eff (dims_eff),
		.dres     (dres),
		.busy     (dist_busy)
	);

	always_comb begin
		if (cfg.dims inside {[1:gnnm_pkg::MAX_DIMS]}) begin
			dims_eff = cfg.dims;
		end else if (cfg.dims == '0) begin
			dims_eff = gnnm_pkg::DIMS_CFG_W'(1);
		end else begin
			dims_eff = gnnm_pkg::DIMS_CFG_W'(gnnm_pkg::MAX_DIMS);
		end
		if (cfg.count == '0) begin
			count_eff = gnnm_pkg::CNT_W'(1);
		end else if (cfg.count > gnnm_pkg::CNT_W'(gnnm_pkg::MAX_POINTS)) begin
			count_eff = gnnm_pkg::CNT_W'(gnnm_pkg::MAX_POINTS);
		end else begin
			count_eff = cfg.count;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign dim_ok    = {1'b0, req.dim_index} < dims_eff;
	assign is_last   = {1'b0, req.dim_index} == (dims_eff - gnnm_pkg::DIMS_CFG_W'(1));
	assign pidx_ok   = {1'b0, req.point_index} < count_eff;
	assign out_free  = !out_valid_q || res.ready;
	assign scan_end  = {1'b0, scan_q} == (count_eff - gnnm_pkg::CNT_W'(1));
	assign best_upd  = dres.valid && dres.live && (!any_q || dres.sqd < best_dist_q);

	always_comb begin
		wr = '0;
		case (state_q)
			ST_CLEAR: begin
				wr.live_en = 1'b1;
				wr.addr    = clr_q;
				wr.live    = 1'b0;
			end
			ST_IDLE: begin
				if (accept && req.req_type == gnnm_pkg::REQ_LOAD && dim_ok && pidx_ok) begin
					wr.coord_en = 1'b1;
					wr.live_en  = is_last;
					wr.addr     = req.point_index;
					wr.dim      = req.dim_index;
					wr.coord    = req.coord_value;
					wr.live     = 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free && any_q) begin
					wr.live_en = 1'b1;
					wr.addr    = best_idx_q;
					wr.live    = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			scan_q      <= '0;
			v_s1        <= 1'b0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (best_upd) begin
				any_q <= 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + gnnm_pkg::IDX_W'(1);
					if (clr_q == gnnm_pkg::IDX_W'(gnnm_pkg::MAX_POINTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && req.req_type == gnnm_pkg::REQ_QUERY && dim_ok && is_last) begin
						state_q <= ST_SCAN;
						scan_q  <= '0;
						any_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + gnnm_pkg::IDX_W'(1);
					if (scan_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !dist_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (accept && req.req_type == gnnm_pkg::REQ_QUERY && dim_ok) begin
			qc_q[req.dim_index] <= req.coord_value;
		end
		if (best_upd) begin
			best_idx_q  <= dres.idx;
			best_dist_q <= dres.sqd;
		end
		if (state_q == ST_DONE && out_free) begin
			out_found_q <= any_q;
			out_match_q <= any_q ? gnnm_pkg::CNT_W'(best_idx_q) + gnnm_pkg::CNT_W'(1) : '0;
			out_dist_q  <= any_q ? best_dist_q : '0;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.found        = out_found_q;
	assign res.match_number = out_match_q;
	assign res.sq_distance  = out_dist_q;

	a_dres_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		dres.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("distance result outside of a scan");

	a_no_wr_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.coord_en || wr.live_en) |-> (state_q != ST_SCAN && state_q != ST_DRAIN))
		else $error("store write while scan reads are in flight");

	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (!v_s1 && !dist_busy))
		else $error("result taken before the pipeline drained");

	a_found_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_found_q == (out_match_q != '0)))
		else $error("found flag disagrees with match number");

	a_remove_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> out_valid_q)
		else $error("result not posted after scan end");

endmodule
